>>> rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the credit-based shaper: event codes,
// register indexes, sequencer states and the divider request/response words.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // event and time widths
  localparam int unsigned TimeW  = 48;
  localparam int unsigned RateW  = 32;
  localparam int unsigned CredW  = 32;
  localparam int unsigned TickW  = 16;
  localparam int unsigned BitsW  = 34;
  localparam int unsigned TicksW = 32;
  localparam int unsigned FramesW = 7;

  // rate-times-time results are capped at 2^33 bits
  localparam logic [BitsW-1:0] BitsCap = 34'h2_0000_0000;

  // divider geometry, one quotient bit a step
  localparam int unsigned DivW    = 48;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  localparam int unsigned DefaultQueueDepth = 64;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0,
    OP_WAKEUP  = 2'd1,
    OP_TX_DONE = 2'd2,
    OP_REFRESH = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_RESERVED_RATE = 2'd0,
    CFG_PORT_RATE     = 2'd1,
    CFG_TICK_LENGTH   = 2'd2,
    CFG_STRETCH_TIME  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SUM,
    ST_UPD1,
    ST_UPD2,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TicksW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/cbs_div.sv
// ----------------------------------------------------------------------------
// cbs_div
// Iterative restoring divider: one quotient bit per cycle, then a rounded-up
// quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module cbs_div
  import cbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivW:0]      rem_shift;
  logic [DivW:0]      rem_diff;
  logic [DivW:0]      quo_ceil;

  // one shift-subtract step
  always_comb begin
    rem_shift = {rem_q, quo_q[DivW-1]};
    rem_diff  = rem_shift - {1'b0, den_q};
    if (!rem_diff[DivW]) begin
      rem_d = rem_diff[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b1};
    end else begin
      rem_d = rem_shift[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // round up and saturate
  always_comb begin
    quo_ceil = {1'b0, quo_q} + {{DivW{1'b0}}, (rem_q != '0)};
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    if (quo_ceil[DivW:TicksW] != '0) rsp_o.quotient = '1;
    else                             rsp_o.quotient = quo_ceil[TicksW-1:0];
  end

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
`endif

endmodule

>>> rtl/credit_based_shaper_core.sv
// Sequence: an accepted word passes MUL_HI, MUL_LO, SUM, UPD1, UPD2 and DONE;
// DEN, DIV_GO and DIV_WAIT (the bit-serial divider run) come before DONE when a
// wakeup delay is computed. Throughput: one word at a time; the next word is taken
// once the sequencer is back in idle; the 32x32 multiplier is shared.
// Reset: asynchronous, active low; credit, times and count clear, tick length 1.
// ----------------------------------------------------------------------------
// credit_based_shaper_core
// Credit-based shaper for one reserved queue: per event credit update, send
// grant or wakeup timer, driven by a small sequencer over one multiplier.
// ----------------------------------------------------------------------------
module credit_based_shaper_core
  import cbs_pkg::*;
#(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  // event words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [TimeW-1:0]    now_time_i,
  input  logic [31:0]         tx_duration_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                send_frame_o,
  output logic                timer_start_o,
  output logic [TicksW-1:0]   timer_ticks_o,
  output logic                queue_cleared_o,
  output logic signed [CredW-1:0] credit_now_o,
  output logic signed [CredW-1:0] credit_peak_o,
  output logic [FramesW-1:0]  frames_waiting_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned ExtW = (CntW > FramesW) ? CntW : FramesW;

  function automatic logic [CredW-1:0] credit_sat(input logic [CredW-1:0] c,
                                                   input logic [BitsW-1:0] b,
                                                   input logic sub);
    logic signed [35:0] s;
    logic signed [35:0] cx;
    logic signed [35:0] bx;
    cx = $signed({{4{c[CredW-1]}}, c});
    bx = $signed({2'b00, b});
    s  = sub ? (cx - bx) : (cx + bx);
    if (s > 36'sd2147483647)       return 32'h7FFF_FFFF;
    else if (s < -36'sd2147483648) return 32'h8000_0000;
    else                           return s[CredW-1:0];
  endfunction

  state_e state_q, state_d;

  // configuration registers
  logic [RateW-1:0] rres_q, rport_q;
  logic [TickW-1:0] tick_q;
  logic [TickW-1:0] stretch_q;

  // shaper state
  logic [CredW-1:0] credit_q, peak_q;
  logic             tx_q;
  logic [TimeW-1:0] last_q, event_q;
  logic [CntW-1:0]  fc_q;

  // per-event working registers
  opcode_e          op_q;
  logic [TimeW-1:0] now_q;
  logic [31:0]      dur_q;
  logic             fwd_q;
  logic [TimeW-1:0] t_q;
  logic [RateW-1:0] rate_q;
  logic [TimeW-1:0] mhi_q;
  logic [63:0]      prod_q;
  logic [BitsW-1:0] bits_q;
  logic [DivW-1:0]  num_q, den_q;
  logic             send_q, timer_q, cleared_q;
  logic [TicksW-1:0] ticks_q;

  // output register
  logic              ov_q;
  logic              o_send_q, o_timer_q, o_clr_q;
  logic [TicksW-1:0] o_ticks_q;
  logic [CredW-1:0]  o_credit_q, o_peak_q;
  logic [ExtW-1:0]   o_fc_q;

  logic              in_acc, out_free;
  logic [TickW-1:0]  tick_eff;
  logic [RateW-1:0]  slope;
  logic [TimeW-1:0]  elapsed;
  logic              fwd_in;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [49:0]       bits_sum;
  logic [CredW-1:0]  c_add, c_sub, c_first, c_cur;
  logic [TimeW:0]    base;
  logic              u_send, u_timer, u_clr, u_drop;
  logic [DivW-1:0]   u_num;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free   = !ov_q || !out_stall_i;
  assign tick_eff   = (tick_q == '0) ? TickW'(1) : tick_q;
  assign slope      = (rport_q > rres_q) ? (rport_q - rres_q) : '0;
  assign fwd_in     = (now_time_i >= last_q);
  assign elapsed    = now_time_i - last_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = rate_q;
    mul_b = t_q[31:0];
    unique case (state_q)
      ST_MUL_HI: mul_b = {16'b0, t_q[TimeW-1:32]};
      ST_DEN: begin
        mul_a = (op_q == OP_TX_DONE) ? 32'd1 : rres_q;
        mul_b = {16'b0, tick_eff};
      end
      default: mul_b = t_q[31:0];
    endcase
  end
  assign prod = {32'b0, mul_a} * {32'b0, mul_b};

  // ceil(rate * t / 65536), capped
  assign bits_sum = {2'b0, mhi_q << 16} + {2'b0, prod_q[63:16]} +
                    {49'b0, (prod_q[15:0] != '0)};

  // credit adders
  assign c_add = credit_sat(credit_q, bits_q, 1'b0);
  assign c_sub = credit_sat(credit_q, bits_q, 1'b1);
  assign c_first = ($signed(c_add) > 0 && fc_q == '0 && !tx_q) ? '0 : c_add;
  assign c_cur   = fwd_q ? c_add : credit_q;

  // time base after a transmission
  assign base = ((last_q <= now_q) ? {1'b0, now_q} : {1'b0, last_q}) +
                {17'b0, dur_q};

  // decisions once the UPD1 credit update is applied
  always_comb begin
    u_send  = 1'b0;
    u_timer = 1'b0;
    u_clr   = 1'b0;
    u_drop  = 1'b0;
    u_num   = '0;
    if (op_q == OP_TX_DONE) begin
      if (fc_q != '0) begin
        if (credit_q[CredW-1]) begin
          u_timer = 1'b1;
          u_num   = {16'b0, dur_q};
        end else begin
          u_send = 1'b1;
        end
      end else if (credit_q != '0 && !credit_q[CredW-1]) begin
        u_clr = (event_q >= last_q);
      end else if (credit_q[CredW-1]) begin
        u_timer = 1'b1;
        u_num   = {15'b0, {1'b0, dur_q} + {17'b0, stretch_q}};
      end
    end else if (!tx_q && op_q != OP_REFRESH) begin
      if (!credit_q[CredW-1]) begin
        if (fc_q != '0) u_send = 1'b1;
        else            u_clr  = fwd_q;
      end else if (rres_q == '0) begin
        u_clr  = fwd_q;
        u_drop = 1'b1;
      end else begin
        u_timer = 1'b1;
        u_num   = {-credit_q, 16'b0};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_SUM;
      ST_SUM:      state_d = ST_UPD1;
      ST_UPD1:     state_d = ST_UPD2;
      ST_UPD2:     state_d = u_timer ? ST_DEN : ST_DONE;
      ST_DEN:      state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_rsp.done) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // divider hookup
  always_comb begin
    div_req.start = (state_q == ST_DIV_GO);
    div_req.num   = num_q;
    div_req.den   = den_q;
  end

  cbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rres_q    <= '0;
      rport_q   <= '0;
      tick_q    <= TickW'(1);
      stretch_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RESERVED_RATE: rres_q    <= cfg_data_i;
        CFG_PORT_RATE:     rport_q   <= cfg_data_i;
        CFG_TICK_LENGTH:   tick_q    <= cfg_data_i[TickW-1:0];
        CFG_STRETCH_TIME:  stretch_q <= cfg_data_i[TickW-1:0];
        default:           rres_q    <= rres_q;
      endcase
    end
  end

  // shaper state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      peak_q   <= '0;
      tx_q     <= 1'b0;
      last_q   <= '0;
      event_q  <= '0;
      fc_q     <= '0;
    end else if (state_q == ST_UPD1) begin
      if (op_q == OP_TX_DONE) begin
        credit_q <= c_sub;
      end else begin
        if (credit_q[CredW-1] && fwd_q) credit_q <= c_first;
        if (op_q == OP_ARRIVAL && fc_q < CntW'(QueueDepth)) fc_q <= fc_q + 1'b1;
      end
    end else if (state_q == ST_UPD2) begin
      if (op_q == OP_TX_DONE) begin
        tx_q <= u_send;
        if (u_clr) credit_q <= '0;
        if (u_send) fc_q <= fc_q - 1'b1;
        last_q <= base[TimeW] ? '1 : base[TimeW-1:0];
      end else begin
        event_q <= now_q;
        if (fwd_q) last_q <= now_q;
        if (tx_q) begin
          credit_q <= c_cur;
          if ($signed(c_cur) > $signed(peak_q)) peak_q <= c_cur;
        end else begin
          if (u_send) begin
            fc_q <= fc_q - 1'b1;
            tx_q <= 1'b1;
          end
          if (u_clr) credit_q <= '0;
          if (u_drop) fc_q <= '0;
        end
      end
    end
  end

  // per-event datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q      <= opcode_e'(opcode_i);
          now_q     <= now_time_i;
          dur_q     <= tx_duration_i;
          fwd_q     <= fwd_in;
          send_q    <= 1'b0;
          timer_q   <= 1'b0;
          cleared_q <= 1'b0;
          ticks_q   <= '0;
          if (opcode_e'(opcode_i) == OP_TX_DONE) begin
            t_q    <= {16'b0, tx_duration_i};
            rate_q <= slope;
          end else begin
            t_q    <= fwd_in ? elapsed : '0;
            rate_q <= rres_q;
          end
        end
      end
      ST_MUL_HI: mhi_q  <= prod[TimeW-1:0];
      ST_MUL_LO: prod_q <= prod;
      ST_SUM: begin
        if ((t_q[TimeW-1:32] != '0 && mhi_q >= TimeW'(16'h8000)) ||
            bits_sum > {16'b0, BitsCap})
          bits_q <= BitsCap;
        else
          bits_q <= bits_sum[BitsW-1:0];
      end
      ST_UPD2: begin
        send_q    <= u_send;
        timer_q   <= u_timer;
        cleared_q <= u_drop;
        num_q     <= u_num;
      end
      ST_DEN:      den_q <= prod[DivW-1:0];
      ST_DIV_WAIT: if (div_rsp.done) ticks_q <= div_rsp.quotient;
      default:     ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      ov_q <= 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      o_send_q   <= send_q;
      o_timer_q  <= timer_q;
      o_ticks_q  <= ticks_q;
      o_clr_q    <= cleared_q;
      o_credit_q <= credit_q;
      o_peak_q   <= peak_q;
      o_fc_q     <= ExtW'(fc_q);
    end
  end

  assign out_valid_o      = ov_q;
  assign send_frame_o     = o_send_q;
  assign timer_start_o    = o_timer_q;
  assign timer_ticks_o    = o_ticks_q;
  assign queue_cleared_o  = o_clr_q;
  assign credit_now_o     = o_credit_q;
  assign credit_peak_o    = o_peak_q;
  assign frames_waiting_o = o_fc_q[FramesW-1:0];

`ifndef SYNTH
  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CntW'(QueueDepth)) else $error("frame count beyond queue depth");
  a_grant_xor_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(o_send_q && o_timer_q)) else $error("grant and timer together");
  a_ticks_need_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !o_timer_q) |-> o_ticks_q == '0) else $error("ticks without timer");
  a_cleared_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_clr_q) |-> o_fc_q == '0) else $error("cleared queue not empty");
`endif

endmodule
